// ===== src/ulcp_pkg.sv =====
// Shared types, character codes, command codes and keyword table for the
// serial line command parser. No dependencies.
package ulcp_pkg;

	localparam int ULCP_LINE_CHARS = 32;
	localparam int QUEUE_DEPTH     = 2;
	localparam int TOK_CHARS       = 6;
	localparam int TOK_LEN_W       = 3;
	localparam int ARG_W           = 31;

	typedef logic [TOK_CHARS-1:0][7:0] tok_t;
	typedef logic [TOK_LEN_W-1:0]      tok_len_t;

	typedef enum logic [1:0] {
		KIND_CHAR  = 2'd0,
		KIND_ERASE = 2'd1,
		KIND_TERM  = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
	} item_t;

	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_DEL = 8'h7F;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_NUL = 8'h00;

	localparam logic [1:0] ST_EMPTY  = 2'd0;
	localparam logic [1:0] ST_SYNTAX = 2'd1;
	localparam logic [1:0] ST_CMD    = 2'd2;

	localparam logic [3:0] OP_UNKNOWN = 4'd0;
	localparam logic [3:0] OP_MODE    = 4'd1;
	localparam logic [3:0] OP_WAVE    = 4'd2;
	localparam logic [3:0] OP_FREQ    = 4'd3;
	localparam logic [3:0] OP_AMP     = 4'd4;
	localparam logic [3:0] OP_START   = 4'd5;
	localparam logic [3:0] OP_STOP    = 4'd6;
	localparam logic [3:0] OP_STATUS  = 4'd7;
	localparam logic [3:0] OP_HELP    = 4'd8;

	localparam logic [1:0] MSEL_DC     = 2'd0;
	localparam logic [1:0] MSEL_AC     = 2'd1;
	localparam logic [1:0] MSEL_FOLLOW = 2'd2;
	localparam logic [1:0] MSEL_FUNC   = 2'd3;

	localparam logic [1:0] WAVE_SINE   = 2'd0;
	localparam logic [1:0] WAVE_SQUARE = 2'd1;
	localparam logic [1:0] WAVE_TRI    = 2'd2;
	localparam logic [1:0] WAVE_SAW    = 2'd3;

	localparam logic [ARG_W-1:0] ARG_SAT = {ARG_W{1'b1}};

	// first character sits at index 0
	localparam tok_t W_MODE   = {8'h00, 8'h00, "E", "D", "O", "M"};
	localparam tok_t W_WAVE   = {8'h00, 8'h00, "E", "V", "A", "W"};
	localparam tok_t W_FREQ   = {8'h00, 8'h00, "Q", "E", "R", "F"};
	localparam tok_t W_AMP    = {8'h00, 8'h00, 8'h00, "P", "M", "A"};
	localparam tok_t W_START  = {8'h00, "T", "R", "A", "T", "S"};
	localparam tok_t W_STOP   = {8'h00, 8'h00, "P", "O", "T", "S"};
	localparam tok_t W_STATUS = {"S", "U", "T", "A", "T", "S"};
	localparam tok_t W_HELP   = {8'h00, 8'h00, "P", "L", "E", "H"};
	localparam tok_t W_DC     = {8'h00, 8'h00, 8'h00, 8'h00, "C", "D"};
	localparam tok_t W_AC     = {8'h00, 8'h00, 8'h00, 8'h00, "C", "A"};
	localparam tok_t W_FOLLOW = {"W", "O", "L", "L", "O", "F"};
	localparam tok_t W_FUNC   = {8'h00, 8'h00, "C", "N", "U", "F"};
	localparam tok_t W_SINE   = {8'h00, 8'h00, "E", "N", "I", "S"};
	localparam tok_t W_SQUARE = {"E", "R", "A", "U", "Q", "S"};
	localparam tok_t W_TRI    = {8'h00, 8'h00, 8'h00, "I", "R", "T"};
	localparam tok_t W_SAW    = {8'h00, 8'h00, 8'h00, "W", "A", "S"};

	function automatic logic tok_eq(tok_t t, tok_len_t n, tok_t w, tok_len_t wn);
		logic eq;
		eq = (n == wn);
		for (int i = 0; i < TOK_CHARS; i++) begin
			if ((TOK_LEN_W'(i) < wn) && (t[i] != w[i]))
				eq = 1'b0;
		end
		return eq;
	endfunction

	function automatic kind_t classify(logic [7:0] c);
		kind_t k;
		if (c == CH_CR || c == CH_LF)
			k = KIND_TERM;
		else if (c == CH_BS || c == CH_DEL)
			k = KIND_ERASE;
		else
			k = KIND_CHAR;
		return k;
	endfunction

endpackage

// ===== src/ulcp_if.sv =====
// Valid/ready channel interfaces of the line command parser: received bytes
// in, decoded line results out. Depends on ulcp_pkg.
interface ulcp_byte_if import ulcp_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface ulcp_result_if import ulcp_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [1:0]       line_status;
	logic [3:0]       command_code;
	logic [1:0]       mode_sel;
	logic [1:0]       wave_sel;
	logic [ARG_W-1:0] arg_value;

	modport source (output valid, output line_status, output command_code,
		output mode_sel, output wave_sel, output arg_value, input ready);
	modport sink (input valid, input line_status, input command_code,
		input mode_sel, input wave_sel, input arg_value, output ready);
endinterface

// ===== src/ulcp_front.sv =====
// Front end: accepts received bytes and classifies each as character, erase
// or terminator into a registered request. Depends on ulcp_pkg, ulcp_if.
module ulcp_front import ulcp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	ulcp_byte_if.sink   rx,
	output item_t       push_item,
	output logic        push_valid,
	input  logic        push_ready
);

	item_t item_q;
	logic  vld_q;

	assign rx.ready   = !vld_q || push_ready;
	assign push_item  = item_q;
	assign push_valid = vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			vld_q <= 1'b1;
		end else if (push_ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			item_q.kind <= classify(rx.rx_byte);
			item_q.data <= rx.rx_byte;
		end
	end

endmodule

// ===== src/ulcp_queue.sv =====
// Short request queue between the front end and the line engine.
// Depends on ulcp_pkg.
module ulcp_queue import ulcp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  item_t push_item,
	input  logic  push_valid,
	output logic  push_ready,
	output item_t pop_item,
	output logic  pop_valid,
	input  logic  pop_ready
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

	item_t         slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (cnt_q != FULL);
	assign pop_valid  = (cnt_q != '0);
	assign pop_item   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= push_item;
	end

endmodule

// ===== src/ulcp_back.sv =====
// Line engine: keeps the line store and length, walks the stored line on a
// terminator, tokenizes, decodes and holds the result. Depends on ulcp_pkg, ulcp_if.
module ulcp_back import ulcp_pkg::*; #(
	parameter int LINE_CHARS = ULCP_LINE_CHARS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  item_t         pop_item,
	input  logic          pop_valid,
	output logic          pop_ready,
	ulcp_result_if.source res
);

	localparam int AW = $clog2(LINE_CHARS);
	localparam logic [AW-1:0] LEN_MAX = AW'(LINE_CHARS - 1);
	localparam tok_len_t TOK_FULL = TOK_LEN_W'(TOK_CHARS);
	localparam tok_len_t TOK_OVER = {TOK_LEN_W{1'b1}};

	typedef enum logic [2:0] {
		BK_IDLE = 3'b001,
		BK_WALK = 3'b010,
		BK_DONE = 3'b100
	} bk_state_t;

	typedef enum logic [4:0] {
		TK_LEAD = 5'b00001,
		TK_VERB = 5'b00010,
		TK_GAP  = 5'b00100,
		TK_ARG  = 5'b01000,
		TK_END  = 5'b10000
	} tk_phase_t;

	typedef enum logic [2:0] {
		NM_WS  = 3'b001,
		NM_DIG = 3'b010,
		NM_END = 3'b100
	} nm_phase_t;

	logic [7:0]       mem [LINE_CHARS];
	bk_state_t        state_q;
	logic [AW-1:0]    len_q;
	logic [AW-1:0]    idx_q;
	logic [7:0]       rd_data_s1;
	logic             rd_vld_s1;
	logic             rd_en;
	logic             wr_en;
	tk_phase_t        tk_q;
	nm_phase_t        nm_q;
	logic             nonempty_q;
	logic             stop_q;
	tok_t             verb_q;
	tok_len_t         verb_len_q;
	tok_t             arg_q;
	tok_len_t         arg_len_q;
	logic             neg_q;
	logic [ARG_W-1:0] mag_q;
	logic             res_valid_q;
	logic             load_res;

	logic [1:0]       res_status_q;
	logic [3:0]       res_code_q;
	logic [1:0]       res_mode_q;
	logic [1:0]       res_wave_q;
	logic [ARG_W-1:0] res_value_q;

	logic [7:0]       ch;
	logic             delim;
	logic             is_digit;
	logic [ARG_W+3:0] mag_sum;
	logic [ARG_W-1:0] mag_sat;
	nm_phase_t        nm_nxt;
	logic             neg_nxt;
	logic [ARG_W-1:0] mag_nxt;

	logic [1:0]       st_d;
	logic [3:0]       code_d;
	logic [1:0]       mode_d;
	logic [1:0]       wave_d;
	logic [ARG_W-1:0] value_d;
	logic             has_arg;
	logic             is_freq;

	assign pop_ready = (state_q == BK_IDLE);
	assign wr_en = (state_q == BK_IDLE) && pop_valid && (pop_item.kind == KIND_CHAR)
		&& (len_q != LEN_MAX);
	assign rd_en = (state_q == BK_WALK) && (idx_q != len_q);
	assign load_res = (state_q == BK_DONE) && (!res_valid_q || res.ready);

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[len_q] <= pop_item.data;
		if (rd_en)
			rd_data_s1 <= mem[idx_q];
	end

	assign ch = (rd_data_s1 >= "a" && rd_data_s1 <= "z") ? rd_data_s1 - 8'h20 : rd_data_s1;
	assign delim = (ch == CH_SP) || (ch == CH_TAB);
	assign is_digit = (ch >= "0") && (ch <= "9");
	assign mag_sum = ({4'b0, mag_q} << 3) + ({4'b0, mag_q} << 1)
		+ (ARG_W + 4)'(ch[3:0]);
	assign mag_sat = (mag_sum > {4'b0, ARG_SAT}) ? ARG_SAT : mag_sum[ARG_W-1:0];

	always_comb begin
		nm_nxt  = nm_q;
		neg_nxt = neg_q;
		mag_nxt = mag_q;
		case (nm_q)
			NM_WS: begin
				if (ch >= CH_TAB && ch <= CH_CR) begin
					nm_nxt = NM_WS;
				end else if (ch == "+" || ch == "-") begin
					neg_nxt = (ch == "-");
					nm_nxt  = NM_DIG;
				end else if (is_digit) begin
					mag_nxt = mag_sat;
					nm_nxt  = NM_DIG;
				end else begin
					nm_nxt = NM_END;
				end
			end
			NM_DIG: begin
				if (is_digit)
					mag_nxt = mag_sat;
				else
					nm_nxt = NM_END;
			end
			default: nm_nxt = nm_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			len_q       <= '0;
			idx_q       <= '0;
			rd_vld_s1   <= 1'b0;
			tk_q        <= TK_LEAD;
			nm_q        <= NM_WS;
			nonempty_q  <= 1'b0;
			stop_q      <= 1'b0;
			verb_q      <= '0;
			verb_len_q  <= '0;
			arg_q       <= '0;
			arg_len_q   <= '0;
			neg_q       <= 1'b0;
			mag_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (load_res)
				res_valid_q <= 1'b1;
			else if (res.ready)
				res_valid_q <= 1'b0;
			rd_vld_s1 <= rd_en;
			if (rd_en)
				idx_q <= idx_q + 1'b1;
			case (state_q)
				BK_IDLE: begin
					if (pop_valid) begin
						case (pop_item.kind)
							KIND_CHAR: begin
								if (len_q != LEN_MAX)
									len_q <= len_q + 1'b1;
							end
							KIND_ERASE: begin
								if (len_q != '0)
									len_q <= len_q - 1'b1;
							end
							KIND_TERM: begin
								state_q    <= BK_WALK;
								idx_q      <= '0;
								tk_q       <= TK_LEAD;
								nm_q       <= NM_WS;
								nonempty_q <= 1'b0;
								stop_q     <= 1'b0;
								verb_len_q <= '0;
								arg_len_q  <= '0;
								neg_q      <= 1'b0;
								mag_q      <= '0;
							end
							default: ;
						endcase
					end
				end
				BK_WALK: begin
					if (rd_vld_s1 && !stop_q) begin
						if (ch == CH_NUL) begin
							stop_q <= 1'b1;
						end else begin
							nonempty_q <= 1'b1;
							case (tk_q)
								TK_LEAD, TK_VERB: begin
									if (!delim) begin
										tk_q <= TK_VERB;
										if (verb_len_q < TOK_FULL)
											verb_q[verb_len_q] <= ch;
										if (verb_len_q != TOK_OVER)
											verb_len_q <= verb_len_q + 1'b1;
									end else if (tk_q == TK_VERB) begin
										tk_q <= TK_GAP;
									end
								end
								TK_GAP, TK_ARG: begin
									if (!delim) begin
										tk_q  <= TK_ARG;
										nm_q  <= nm_nxt;
										neg_q <= neg_nxt;
										mag_q <= mag_nxt;
										if (arg_len_q < TOK_FULL)
											arg_q[arg_len_q] <= ch;
										if (arg_len_q != TOK_OVER)
											arg_len_q <= arg_len_q + 1'b1;
									end else if (tk_q == TK_ARG) begin
										tk_q <= TK_END;
									end
								end
								default: ;
							endcase
						end
					end
					if (!rd_en && !rd_vld_s1)
						state_q <= BK_DONE;
				end
				BK_DONE: begin
					if (load_res) begin
						len_q   <= '0;
						state_q <= BK_IDLE;
					end
				end
				default: state_q <= BK_IDLE;
			endcase
		end
	end

	assign has_arg = (arg_len_q != '0);
	assign is_freq = tok_eq(verb_q, verb_len_q, W_FREQ, 3'd4);

	always_comb begin
		st_d    = ST_SYNTAX;
		code_d  = OP_UNKNOWN;
		mode_d  = MSEL_DC;
		wave_d  = WAVE_SINE;
		value_d = '0;
		if (!nonempty_q) begin
			st_d = ST_EMPTY;
		end else if (verb_len_q == '0) begin
			st_d = ST_SYNTAX;
		end else if (tok_eq(verb_q, verb_len_q, W_MODE, 3'd4)) begin
			st_d   = ST_CMD;
			code_d = OP_MODE;
			if (tok_eq(arg_q, arg_len_q, W_DC, 3'd2))
				mode_d = MSEL_DC;
			else if (tok_eq(arg_q, arg_len_q, W_AC, 3'd2))
				mode_d = MSEL_AC;
			else if (tok_eq(arg_q, arg_len_q, W_FOLLOW, 3'd6))
				mode_d = MSEL_FOLLOW;
			else if (tok_eq(arg_q, arg_len_q, W_FUNC, 3'd4))
				mode_d = MSEL_FUNC;
			else begin
				st_d   = ST_SYNTAX;
				code_d = OP_UNKNOWN;
			end
		end else if (tok_eq(verb_q, verb_len_q, W_WAVE, 3'd4)) begin
			st_d   = ST_CMD;
			code_d = OP_WAVE;
			if (tok_eq(arg_q, arg_len_q, W_SINE, 3'd4))
				wave_d = WAVE_SINE;
			else if (tok_eq(arg_q, arg_len_q, W_SQUARE, 3'd6))
				wave_d = WAVE_SQUARE;
			else if (tok_eq(arg_q, arg_len_q, W_TRI, 3'd3))
				wave_d = WAVE_TRI;
			else if (tok_eq(arg_q, arg_len_q, W_SAW, 3'd3))
				wave_d = WAVE_SAW;
			else begin
				st_d   = ST_SYNTAX;
				code_d = OP_UNKNOWN;
			end
		end else if (is_freq || tok_eq(verb_q, verb_len_q, W_AMP, 3'd3)) begin
			if (has_arg) begin
				st_d = ST_CMD;
				if (neg_q && (mag_q != '0)) begin
					code_d = OP_UNKNOWN;
				end else if (is_freq && (mag_q == '0)) begin
					code_d = OP_UNKNOWN;
				end else begin
					code_d  = is_freq ? OP_FREQ : OP_AMP;
					value_d = mag_q;
				end
			end
		end else begin
			st_d = ST_CMD;
			if (tok_eq(verb_q, verb_len_q, W_START, 3'd5))
				code_d = OP_START;
			else if (tok_eq(verb_q, verb_len_q, W_STOP, 3'd4))
				code_d = OP_STOP;
			else if (tok_eq(verb_q, verb_len_q, W_STATUS, 3'd6))
				code_d = OP_STATUS;
			else if (tok_eq(verb_q, verb_len_q, W_HELP, 3'd4))
				code_d = OP_HELP;
			else
				code_d = OP_UNKNOWN;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_status_q <= st_d;
			res_code_q   <= code_d;
			res_mode_q   <= mode_d;
			res_wave_q   <= wave_d;
			res_value_q  <= value_d;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.line_status  = res_status_q;
	assign res.command_code = res_code_q;
	assign res.mode_sel     = res_mode_q;
	assign res.wave_sel     = res_wave_q;
	assign res.arg_value    = res_value_q;

endmodule

// ===== src/uart_line_command_parser.sv =====
// A character or erase request passes the front-end register and the queue
// before it reaches the line store; a terminator starts a walk of the stored
// line, one stored character read per cycle, then the result is registered.
// Throughput: one byte per cycle into the queue while it has room; the line
// engine drains one request per cycle while idle, and a terminator holds it
// through the walk plus any wait for the result register.
// Reset clears the length and all handshakes; the line store is not cleared.
module uart_line_command_parser import ulcp_pkg::*; #(
	parameter int LINE_CHARS = ULCP_LINE_CHARS
) (
	input  logic          clk,
	input  logic          arst_n,
	ulcp_byte_if.sink     rx,
	ulcp_result_if.source res
);

	item_t push_item;
	logic  push_valid;
	logic  push_ready;
	item_t pop_item;
	logic  pop_valid;
	logic  pop_ready;

	ulcp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx),
		.push_item  (push_item),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	ulcp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_item  (push_item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_item   (pop_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready)
	);

	ulcp_back #(
		.LINE_CHARS (LINE_CHARS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_item  (pop_item),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.res       (res)
	);

endmodule
